// ===== rtl/stc_pkg.sv =====
package stc_pkg;

    localparam int DEF_ROWS    = 25;
    localparam int DEF_COLUMNS = 80;

    localparam int CODE_W   = 8;
    localparam int ROWSEL_W = 5;
    localparam int COLSEL_W = 7;
    localparam int COLOR_W  = 4;
    localparam int CADDR_W  = 11;
    localparam int WORD_W   = 16;
    // Holds read_row * COLUMNS + read_col for any field values.
    localparam int LIN_W    = ROWSEL_W + COLSEL_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;

    typedef enum logic [1:0] {
        MODE_PUT  = 2'd0,
        MODE_EOL  = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BACKGROUND = 1'b0,
        REG_FOREGROUND = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic clear_all;
        logic clear_row;
        logic put;
        logic eol;
        logic read_req;
        logic read_addr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic row_clear_last;
        logic row_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/scrolling_text_console_unit.sv =====
// Put-character and end-of-line requests are taken without leaving the idle state, but see below for the bottom row.
// A read request passes states ADDR and OUT before its result enters the output register;
// input is held off until then, and OUT waits while the previous result still waits for m_tready.
// An end of line on the bottom row stalls input while the new row is cleared.
// After reset (rst_n, asynchronous) the whole store is cleared before input
// is accepted; colors reset to background 0 and foreground 7, cursor to row 0, column 0.
module scrolling_text_console_unit
    import stc_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int COLUMNS = DEF_COLUMNS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]            s_tuser,   // mode[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cell_address[10:0], cell_word[26:11]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_data
);

    cmd_t               cmd;
    status_t            status;
    logic [CADDR_W-1:0] cell_address;
    logic [WORD_W-1:0]  cell_word;

    stc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_mode  (s_tuser),
        .req_ready (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    stc_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .char_code    (s_tdata[7:0]),
        .read_row     (s_tdata[12:8]),
        .read_col     (s_tdata[19:13]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .cell_address (cell_address),
        .cell_word    (cell_word)
    );

    assign m_tdata = {(OUT_DATA_W - CADDR_W - WORD_W)'(0), cell_word, cell_address};

endmodule

// ===== rtl/stc_ctrl.sv =====
module stc_ctrl
    import stc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_mode,
    output logic       req_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADDR,
        ST_OUT,
        ST_SCROLL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == ST_IDLE);
        case (state_reg)
            ST_INIT:
            begin
                cmd.clear_all = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_mode)
                        MODE_PUT:
                        begin
                            cmd.put = 1'b1;
                        end
                        MODE_EOL:
                        begin
                            cmd.eol = 1'b1;
                            if (status.row_last)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                        MODE_READ:
                        begin
                            cmd.read_req = 1'b1;
                            state_next   = ST_ADDR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADDR:
            begin
                cmd.read_addr = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                cmd.clear_row = 1'b1;
                if (status.row_clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/stc_datapath.sv =====
module stc_datapath
    import stc_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int COLUMNS = DEF_COLUMNS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [ROWSEL_W-1:0]  read_row,
    input  logic [COLSEL_W-1:0]  read_col,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CADDR_W-1:0]   cell_address,
    output logic [WORD_W-1:0]    cell_word
);

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    logic [CODE_W-1:0] mem [TOTAL];

    logic [COLOR_W-1:0] bg_reg, fg_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  cur_base_reg, cur_base_next;
    logic [ADDR_W-1:0]  top_base_reg, top_base_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [LIN_W-1:0]   lin_reg;
    logic               in_range_reg;
    logic [CODE_W-1:0]  rd_q_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CADDR_W-1:0] out_addr_reg;
    logic [WORD_W-1:0]  out_word_reg;

    logic [ADDR_W:0]    cur_adv, top_adv, phys_sum;
    logic [ADDR_W-1:0]  phys_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CODE_W-1:0]  wr_data;
    logic               rd_en;

    assign status.init_last      = (cnt_reg == ADDR_W'(TOTAL - 1));
    assign status.row_clear_last = (cnt_reg == ADDR_W'(COLUMNS - 1));
    assign status.row_last       = (row_reg == ROW_W'(ROWS - 1));
    assign status.out_free       = !out_valid_reg || out_ready;

    // Rows live in a ring: advancing a base by one row wraps at the end of the store.
    always_comb
    begin
        cur_adv = {1'b0, cur_base_reg} + (ADDR_W + 1)'(COLUMNS);
        if (cur_adv == (ADDR_W + 1)'(TOTAL))
        begin
            cur_adv = '0;
        end
        top_adv = {1'b0, top_base_reg} + (ADDR_W + 1)'(COLUMNS);
        if (top_adv == (ADDR_W + 1)'(TOTAL))
        begin
            top_adv = '0;
        end
        phys_sum = {1'b0, ADDR_W'(lin_reg)} + {1'b0, top_base_reg};
        if (phys_sum >= (ADDR_W + 1)'(TOTAL))
        begin
            phys_sum = phys_sum - (ADDR_W + 1)'(TOTAL);
        end
        phys_addr = phys_sum[ADDR_W-1:0];
    end

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        cur_base_next = cur_base_reg;
        top_base_next = top_base_reg;
        cnt_next      = cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_base_reg + ADDR_W'(col_reg);
        wr_data       = char_code;
        rd_en         = cmd.read_addr && in_range_reg;

        if (cmd.clear_all)
        begin
            wr_en    = 1'b1;
            wr_addr  = cnt_reg;
            wr_data  = '0;
            cnt_next = status.init_last ? '0 : cnt_reg + 1'b1;
        end
        if (cmd.clear_row)
        begin
            wr_en    = 1'b1;
            wr_addr  = cur_base_reg + cnt_reg;
            wr_data  = '0;
            cnt_next = status.row_clear_last ? '0 : cnt_reg + 1'b1;
        end
        if (cmd.put && (col_reg < COL_W'(COLUMNS)))
        begin
            wr_en    = 1'b1;
            col_next = col_reg + 1'b1;
        end
        if (cmd.eol)
        begin
            col_next = '0;
            if (status.row_last)
            begin
                // The old top row becomes the new bottom row and is swept to zero.
                cur_base_next = top_base_reg;
                top_base_next = top_adv[ADDR_W-1:0];
            end
            else
            begin
                row_next      = row_reg + 1'b1;
                cur_base_next = cur_adv[ADDR_W-1:0];
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg        <= '0;
            fg_reg        <= FG_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_base_reg  <= '0;
            top_base_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            cur_base_reg  <= cur_base_next;
            top_base_reg  <= top_base_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BACKGROUND: bg_reg <= cfg_data;
                    REG_FOREGROUND: fg_reg <= cfg_data;
                    default:        bg_reg <= bg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[phys_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_req)
        begin
            lin_reg      <= LIN_W'(read_row * COLUMNS) + LIN_W'(read_col);
            in_range_reg <= (read_row < ROWS) && (read_col < COLUMNS);
        end
        if (cmd.load_out)
        begin
            out_addr_reg <= lin_reg[CADDR_W-1:0];
            out_word_reg <= {bg_reg, fg_reg, in_range_reg ? rd_q_reg : CODE_W'(0)};
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_address = out_addr_reg;
    assign cell_word    = out_word_reg;

endmodule

// ===== sim/console_cell_checker.sv =====
module console_cell_checker
    import stc_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int COLUMNS = DEF_COLUMNS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]            s_tuser,   // mode[1:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // cell_address[10:0], cell_word[26:11]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_data,
    output int                    reads_due,
    output int                    fail_count
);

    typedef struct packed {
        logic [CADDR_W-1:0] cell_address;
        logic [WORD_W-1:0]  cell_word;
    } cell_read_t;

    logic [CODE_W-1:0]  screen_codes [ROWS*COLUMNS];
    logic [ROWSEL_W-1:0] cursor_row;
    int                  cursor_col;
    logic [COLOR_W-1:0]  bg_color;
    logic [COLOR_W-1:0]  fg_color;
    cell_read_t          cell_reads_pending [$];

    task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                   input logic [OUT_DATA_W-1:0] want);
    begin
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        fail_count = fail_count + 1;
    end
    endtask

    task automatic clear_console();
    begin
        for (int i = 0; i < ROWS * COLUMNS; i++)
        begin
            screen_codes[i] = '0;
        end
        cursor_row = '0;
        cursor_col = 0;
        bg_color   = '0;
        fg_color   = FG_RESET;
        cell_reads_pending.delete();
    end
    endtask

    task automatic apply_console_request(input logic [1:0] mode,
                                         input logic [IN_DATA_W-1:0] data);
        logic [CODE_W-1:0]   code;
        logic [ROWSEL_W-1:0] row;
        logic [COLSEL_W-1:0] col;
        logic [CODE_W-1:0]   stored_code;
        int                  lin;
        cell_read_t          due;
    begin
        code = data[CODE_W-1:0];
        row  = data[CODE_W +: ROWSEL_W];
        col  = data[CODE_W+ROWSEL_W +: COLSEL_W];
        case (mode)
            MODE_PUT:
            begin
                // Characters past the end of the line are dropped.
                if (cursor_col < COLUMNS)
                begin
                    screen_codes[cursor_row * COLUMNS + cursor_col] = code;
                    cursor_col = cursor_col + 1;
                end
            end
            MODE_EOL:
            begin
                cursor_col = 0;
                if (cursor_row >= ROWS - 1)
                begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                    begin
                        screen_codes[i] = screen_codes[i + COLUMNS];
                    end
                    for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
                    begin
                        screen_codes[i] = '0;
                    end
                end
                else
                begin
                    cursor_row = cursor_row + 1'b1;
                end
            end
            MODE_READ:
            begin
                // Reads off the screen still answer, with a zero code.
                stored_code = '0;
                if (row < ROWS && col < COLUMNS)
                begin
                    stored_code = screen_codes[row * COLUMNS + col];
                end
                lin              = row * COLUMNS + col;
                due.cell_address = lin[CADDR_W-1:0];
                due.cell_word    = {bg_color, fg_color, stored_code};
                cell_reads_pending.push_back(due);
            end
            default:
            begin
            end
        endcase
    end
    endtask

    task automatic check_cell_read(input logic [OUT_DATA_W-1:0] beat);
        cell_read_t want;
    begin
        if (cell_reads_pending.size() == 0)
        begin
            report_mismatch("unrequested cell read", beat, '0);
        end
        else
        begin
            want = cell_reads_pending.pop_front();
            if (beat[CADDR_W-1:0] !== want.cell_address)
            begin
                report_mismatch("cell_address", OUT_DATA_W'(beat[CADDR_W-1:0]),
                                OUT_DATA_W'(want.cell_address));
            end
            if (beat[CADDR_W +: WORD_W] !== want.cell_word)
            begin
                report_mismatch("cell_word", OUT_DATA_W'(beat[CADDR_W +: WORD_W]),
                                OUT_DATA_W'(want.cell_word));
            end
        end
    end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_console();
            fail_count = 0;
            reads_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BACKGROUND)
                begin
                    bg_color = cfg_data;
                end
                else if (cfg_index == REG_FOREGROUND)
                begin
                    fg_color = cfg_data;
                end
            end
            if (m_tvalid && m_tready)
            begin
                check_cell_read(m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                apply_console_request(s_tuser, s_tdata);
            end
            reads_due <= cell_reads_pending.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top
    import stc_pkg::*;
;

    localparam int ROWS        = DEF_ROWS;
    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int CYCLE_LIMIT = 1000000;
    // The block has no use for this mode and must ignore it.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // char_code[7:0], read_row[12:8], read_col[19:13]
    logic [1:0]            s_tuser;   // mode[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // cell_address[10:0], cell_word[26:11]
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COLOR_W-1:0]    cfg_data;
    int                    reads_due;
    int                    fail_count;
    logic                  quiet_tail;
    int                    ready_hold;
    int                    cycle_count;

    scrolling_text_console_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    console_cell_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .reads_due  (reads_due),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result backpressure comes in bursts; it stops for the last phase.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (quiet_tail)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(1, 10) - 1;
        end
    end

    // Sends one request; returns in the time step of its acceptance.
    task automatic send_request(input logic [1:0] mode, input logic [CODE_W-1:0] code,
                                input logic [ROWSEL_W-1:0] row,
                                input logic [COLSEL_W-1:0] col);
    begin
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_DATA_W - CODE_W - ROWSEL_W - COLSEL_W){1'b0}}, col, row, code};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    end
    endtask

    task automatic wait_for_idle();
    begin
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (reads_due != 0)
        begin
            @(posedge clk);
        end
        // A bottom-row line feed may still be clearing the new row.
        repeat (COLUMNS + 20) @(posedge clk);
    end
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg);
    begin
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_index <= REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_we    <= 1'b0;
    end
    endtask

    task automatic send_random_read();
        logic [ROWSEL_W-1:0] row;
        logic [COLSEL_W-1:0] col;
    begin
        if ($urandom_range(0, 9) == 0)
        begin
            row = ROWSEL_W'($urandom_range(0, 31));
            col = COLSEL_W'($urandom_range(0, 127));
        end
        else
        begin
            row = ROWSEL_W'($urandom_range(0, ROWS - 1));
            col = ($urandom_range(0, 1) == 0) ? COLSEL_W'($urandom_range(0, 20))
                                              : COLSEL_W'($urandom_range(0, COLUMNS - 1));
        end
        send_request(MODE_READ, CODE_W'($urandom_range(0, 255)), row, col);
    end
    endtask

    // Typed lines with reads and ignored spare-mode requests mixed in, each closed by a line feed.
    task automatic type_lines(input int item_count);
        int sent;
        int line_len;
        int pick;
    begin
        sent = 0;
        while (sent < item_count)
        begin
            line_len = ($urandom_range(0, 6) == 0) ? $urandom_range(75, 100)
                                                   : $urandom_range(0, 20);
            for (int k = 0; k < line_len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    send_request(MODE_PUT, CODE_W'($urandom_range(0, 255)),
                                 ROWSEL_W'($urandom_range(0, 31)),
                                 COLSEL_W'($urandom_range(0, 127)));
                    sent++;
                end
                else if (pick < 95)
                begin
                    send_random_read();
                    sent++;
                end
                else
                begin
                    send_request(MODE_SPARE, CODE_W'($urandom_range(0, 255)),
                                 ROWSEL_W'($urandom_range(0, 31)),
                                 COLSEL_W'($urandom_range(0, 127)));
                end
            end
            send_request(MODE_EOL, CODE_W'($urandom_range(0, 255)),
                         ROWSEL_W'($urandom_range(0, 31)),
                         COLSEL_W'($urandom_range(0, 127)));
            sent++;
        end
    end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_PUT;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_BACKGROUND;
        cfg_data    = '0;
        quiet_tail  = 1'b0;
        ready_hold  = 0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset colors: code extremes, zero code,
        // ignored mode, off-screen reads and a line feed.
        send_request(MODE_PUT, 8'h00, '0, '0);
        send_request(MODE_PUT, 8'hFF, '0, '0);
        send_request(MODE_PUT, 8'h5A, '1, '1);
        send_request(MODE_READ, '0, 5'd0, 7'd0);
        send_request(MODE_READ, '0, 5'd0, 7'd1);
        send_request(MODE_READ, '0, 5'd0, 7'd2);
        send_request(MODE_READ, '0, 5'd0, 7'd3);
        send_request(MODE_SPARE, 8'hFF, '1, '1);
        send_request(MODE_READ, '0, 5'd0, 7'd2);
        send_request(MODE_READ, '1, 5'd24, 7'd79);
        send_request(MODE_READ, '0, 5'd31, 7'd127);
        send_request(MODE_READ, '0, 5'd25, 7'd0);
        send_request(MODE_READ, '0, 5'd0, 7'd80);
        send_request(MODE_EOL, '1, '1, '1);
        send_request(MODE_PUT, 8'hA5, '0, '0);
        send_request(MODE_READ, '0, 5'd1, 7'd0);
        send_request(MODE_READ, '0, 5'd0, 7'd0);
        send_request(MODE_READ, '0, 5'd1, 7'd1);

        set_colors(4'd15, 4'd0);
        type_lines(350);
        set_colors(4'd0, 4'd15);
        type_lines(350);
        set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
        type_lines(350);
        set_colors(4'd15, 4'd15);
        quiet_tail <= 1'b1;
        type_lines(350);

        wait_for_idle();
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== scrolling_text_console_unit.f =====
rtl/stc_pkg.sv
rtl/stc_ctrl.sv
rtl/stc_datapath.sv
rtl/scrolling_text_console_unit.sv
sim/console_cell_checker.sv
sim/tb_top.sv
